>>> rtl/btgr_pkg.sv
// ----------------------------------------------------------------------------
// btgr_pkg
// Shared constants and the 5x7 font table of the bitmap text rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package btgr_pkg;

  localparam int unsigned GLYPH_ROWS = 7;
  localparam int unsigned GLYPH_COLS = 5;
  localparam int unsigned GLYPH_BITS = GLYPH_ROWS * GLYPH_COLS;
  localparam int unsigned COL_W      = 3;   // holds column 0..4
  localparam int unsigned OFS_W      = 7;   // holds 6 * 15 = 90
  localparam int unsigned SCALE_W    = 4;
  localparam int unsigned COLOR_W    = 32;
  localparam int unsigned FIELD_W    = 16;  // width of the coordinate fields

  localparam int unsigned IN_TDATA_W  = 80; // 76 payload bits, zero filled
  localparam int unsigned OUT_TDATA_W = 72; // 68 payload bits, zero filled

  typedef logic [GLYPH_BITS-1:0] glyph_t;

  // Bitmap of one character, row 0 in the top five bits, column 0 as the
  // upper bit of each row. Codes not in the table draw a question mark.
  function automatic glyph_t font_glyph(input logic [7:0] code);
    glyph_t g;
    unique case (code)
      8'h41: g = {5'h04, 5'h0A, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11}; // A
      8'h43: g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E}; // C
      8'h44: g = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E}; // D
      8'h45: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F}; // E
      8'h49: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F}; // I
      8'h4C: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F}; // L
      8'h4D: g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11}; // M
      8'h30: g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E}; // 0
      8'h31: g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E}; // 1
      8'h32: g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F}; // 2
      8'h33: g = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E}; // 3
      8'h34: g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02}; // 4
      8'h35: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E}; // 5
      8'h36: g = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E}; // 6
      8'h37: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08}; // 7
      8'h38: g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E}; // 8
      8'h39: g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E}; // 9
      8'h48: g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11}; // H
      8'h4E: g = {5'h11, 5'h19, 5'h19, 5'h15, 5'h13, 5'h13, 5'h11}; // N
      8'h4F: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}; // O
      8'h50: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10}; // P
      8'h52: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11}; // R
      8'h53: g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E}; // S
      8'h54: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04}; // T
      8'h55: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}; // U
      8'h56: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04}; // V
      8'h57: g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A}; // W
      8'h58: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11}; // X
      8'h59: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04}; // Y
      8'h21: g = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04}; // !
      8'h2E: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C}; // .
      8'h2F: g = {5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h08, 5'h10}; // /
      8'h3A: g = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00}; // :
      8'h20: g = '0;                                                 // space
      default: g = {5'h1F, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

>>> rtl/bitmap_text_glyph_rasterizer_core.sv
// ----------------------------------------------------------------------------
// bitmap_text_glyph_rasterizer_core
// Turns a stream of text characters into a stream of filled squares, one
// square per lit pixel of a fixed 5x7 font.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one character per transaction. tuser set loads the pen
//   origin, the pixel scale (0 taken as 1) and the color before drawing.
//   Master channel: one square per lit font pixel in raster order, tlast on
//   the final square of the character. A blank glyph gives no transaction.
// Timing:
//   The glyph bitmap is registered out of the font table at acceptance, then
//   the scanner walks it one font pixel per cycle, unless a stalled receiver
//   holds it on a lit pixel, until no lit pixel is left, and then advances
//   the pen in a scan step of its own before it returns to idle.
//   The output register parts the two sides: a stalled receiver holds the
//   scanner only on a lit pixel, and the next character can be accepted
//   while the final square still waits.
// Reset:
//   Pen at (0,0), scale 1, color 0, no square pending.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_text_glyph_rasterizer_core
  import btgr_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  // [7:0] char_code, [23:8] origin_x, [39:24] origin_y, [43:40] pixel_scale,
  // [75:44] text_color, [79:76] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] start_of_string
  input  wire logic                   s_axis_tuser,
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [15:0] square_x, [31:16] square_y, [35:32] square_size,
  // [67:36] square_color, [71:68] zero
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output      logic                   m_axis_tlast
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                  state_q, state_d;
  glyph_t                glyph_q, glyph_d;
  logic [COL_W-1:0]      col_q, col_d;
  logic [OFS_W-1:0]      xoff_q, xoff_d;
  logic [OFS_W-1:0]      yoff_q, yoff_d;
  logic [COORD_BITS-1:0] pen_x_q, pen_x_d;
  logic [COORD_BITS-1:0] pen_y_q, pen_y_d;
  logic [SCALE_W-1:0]    scale_q, scale_d;
  logic [COLOR_W-1:0]    color_q, color_d;

  logic                  out_valid_q, out_valid_d;
  logic [FIELD_W-1:0]    out_x_q, out_y_q;
  logic [SCALE_W-1:0]    out_size_q;
  logic [COLOR_W-1:0]    out_color_q;
  logic                  out_last_q;

  logic                  in_fire;
  logic                  out_free;
  logic                  pix_lit;
  logic                  last_pix;
  logic                  step;
  logic                  load_out;
  logic [SCALE_W-1:0]    in_scale;
  logic signed [31:0]    in_ox_ext, in_oy_ext;
  logic [COORD_BITS-1:0] sq_x, sq_y;
  logic [31:0]           sq_x_ext, sq_y_ext;
  logic [OFS_W-1:0]      advance;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign pix_lit  = glyph_q[GLYPH_BITS-1];
  assign last_pix = (glyph_q[GLYPH_BITS-2:0] == '0);
  assign step     = (state_q == ST_SCAN) && (glyph_q != '0) && (!pix_lit || out_free);
  assign load_out = step && pix_lit;

  assign in_scale  = (s_axis_tdata[43:40] == '0) ? SCALE_W'(1) : s_axis_tdata[43:40];
  assign in_ox_ext = 32'(signed'(s_axis_tdata[23:8]));
  assign in_oy_ext = 32'(signed'(s_axis_tdata[39:24]));

  assign sq_x     = pen_x_q + {{(COORD_BITS-OFS_W){1'b0}}, xoff_q};
  assign sq_y     = pen_y_q + {{(COORD_BITS-OFS_W){1'b0}}, yoff_q};
  assign sq_x_ext = 32'(sq_x);
  assign sq_y_ext = 32'(sq_y);
  assign advance  = {1'b0, scale_q, 2'b00} + {2'b00, scale_q, 1'b0};

  always_comb begin
    state_d = state_q;
    glyph_d = glyph_q;
    col_d   = col_q;
    xoff_d  = xoff_q;
    yoff_d  = yoff_q;
    pen_x_d = pen_x_q;
    pen_y_d = pen_y_q;
    scale_d = scale_q;
    color_d = color_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          // registered font read; counters restart at the top left pixel
          glyph_d = font_glyph(s_axis_tdata[7:0]);
          col_d   = '0;
          xoff_d  = '0;
          yoff_d  = '0;
          if (s_axis_tuser) begin
            pen_x_d = in_ox_ext[COORD_BITS-1:0];
            pen_y_d = in_oy_ext[COORD_BITS-1:0];
            scale_d = in_scale;
            color_d = s_axis_tdata[75:44];
          end
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (glyph_q == '0) begin
          pen_x_d = pen_x_q + {{(COORD_BITS-OFS_W){1'b0}}, advance};
          state_d = ST_IDLE;
        end else if (step) begin
          glyph_d = {glyph_q[GLYPH_BITS-2:0], 1'b0};
          if (col_q == COL_W'(GLYPH_COLS - 1)) begin
            col_d  = '0;
            xoff_d = '0;
            yoff_d = yoff_q + OFS_W'(scale_q);
          end else begin
            col_d  = col_q + COL_W'(1);
            xoff_d = xoff_q + OFS_W'(scale_q);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      glyph_q     <= '0;
      col_q       <= '0;
      xoff_q      <= '0;
      yoff_q      <= '0;
      pen_x_q     <= '0;
      pen_y_q     <= '0;
      scale_q     <= SCALE_W'(1);
      color_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      glyph_q     <= glyph_d;
      col_q       <= col_d;
      xoff_q      <= xoff_d;
      yoff_q      <= yoff_d;
      pen_x_q     <= pen_x_d;
      pen_y_q     <= pen_y_d;
      scale_q     <= scale_d;
      color_q     <= color_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_x_q     <= sq_x_ext[FIELD_W-1:0];
      out_y_q     <= sq_y_ext[FIELD_W-1:0];
      out_size_q  <= scale_q;
      out_color_q <= color_q;
      out_last_q  <= last_pix;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {4'b0000, out_color_q, out_size_q, out_y_q, out_x_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_scale_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scale_q != '0)
    else $error("held scale is zero");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q < COL_W'(GLYPH_COLS))
    else $error("column counter out of range");

  a_last_empties_glyph: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && last_pix) |=> (glyph_q == '0))
    else $error("square marked last while lit pixels remain");

  a_finish_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && glyph_q == '0) |=> (state_q == ST_IDLE))
    else $error("scanner did not finish the character");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !load_out)
    else $error("pending square overwritten");

endmodule

`default_nettype wire

>>> sim/btgr_square_checker.sv
// ----------------------------------------------------------------------------
// btgr_square_checker
// Watches both stream channels of the glyph rasterizer. It predicts the
// squares of every accepted character from its own pen state and font table,
// and compares each square that leaves the block with the oldest prediction.
// ----------------------------------------------------------------------------
module btgr_square_checker
  import btgr_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  input  wire logic                   s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                   s_axis_tuser,
  input  wire logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire logic                   m_axis_tlast,
  output int                          fail_count_o,
  output int                          squares_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [3:0]  size;
    logic [31:0] color;
    logic        last;
  } square_t;

  square_t     squares_due[$];
  logic [15:0] pen_x;
  logic [15:0] pen_y;
  logic [3:0]  pen_scale;
  logic [31:0] pen_color;

  // Row 0 in the top five bits, column 0 as the upper bit of each row.
  function automatic logic [34:0] font_bits(input logic [7:0] code);
    logic [34:0] b;
    case (code)
      "A": b = {5'h04, 5'h0A, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11};
      "C": b = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
      "D": b = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
      "E": b = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      "I": b = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
      "L": b = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      "M": b = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
      "0": b = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      "1": b = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      "2": b = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      "3": b = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
      "4": b = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      "5": b = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
      "6": b = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      "7": b = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      "8": b = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      "9": b = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
      "H": b = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      "N": b = {5'h11, 5'h19, 5'h19, 5'h15, 5'h13, 5'h13, 5'h11};
      "O": b = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      "P": b = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      "R": b = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      "S": b = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      "T": b = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      "U": b = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      "V": b = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      "W": b = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
      "X": b = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
      "Y": b = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      "!": b = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04};
      ".": b = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C};
      "/": b = {5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h08, 5'h10};
      ":": b = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
      " ": b = '0;
      // anything else draws a question mark
      default: b = {5'h1F, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};
    endcase
    return b;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got)
      report_mismatch($sformatf("square %s: expected %h, got %h", name, want, got));
  endtask

  // Queue the squares of one character in raster order, then advance the pen.
  task automatic predict_glyph(input logic [7:0] code);
    logic [34:0] bits;
    logic [15:0] step;
    square_t     sq;
    int          lit;
    int          n;
    bits = font_bits(code);
    step = {12'b0, pen_scale};
    lit  = $countones(bits);
    n    = 0;
    for (int r = 0; r < 7; r++) begin
      for (int c = 0; c < 5; c++) begin
        if (bits[34 - 5*r - c]) begin
          n++;
          sq.x     = pen_x + 16'(c) * step;
          sq.y     = pen_y + 16'(r) * step;
          sq.size  = pen_scale;
          sq.color = pen_color;
          sq.last  = (n == lit);
          squares_due.push_back(sq);
        end
      end
    end
    pen_x = pen_x + 16'd6 * step;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    square_t want;
    if (!rst_ni) begin
      pen_x         = '0;
      pen_y         = '0;
      pen_scale     = 4'd1;
      pen_color     = '0;
      squares_due.delete();
      fail_count_o  = 0;
      squares_due_o = 0;
    end else begin
      // Compare outputs first: a square leaving now never belongs to the
      // character accepted on the same edge.
      if (m_axis_tvalid && m_axis_tready) begin
        if (squares_due.size() == 0) begin
          report_mismatch($sformatf("unexpected square, tdata %h", m_axis_tdata));
        end else begin
          want = squares_due.pop_front();
          check_field("x", 32'(want.x), 32'(m_axis_tdata[15:0]));
          check_field("y", 32'(want.y), 32'(m_axis_tdata[31:16]));
          check_field("size", 32'(want.size), 32'(m_axis_tdata[35:32]));
          check_field("color", want.color, m_axis_tdata[67:36]);
          check_field("pad", 32'd0, 32'(m_axis_tdata[71:68]));
          check_field("tlast", 32'(want.last), 32'(m_axis_tlast));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser) begin
          pen_x     = s_axis_tdata[23:8];
          pen_y     = s_axis_tdata[39:24];
          pen_scale = (s_axis_tdata[43:40] == 4'd0) ? 4'd1 : s_axis_tdata[43:40];
          pen_color = s_axis_tdata[75:44];
        end
        predict_glyph(s_axis_tdata[7:0]);
      end
      squares_due_o = squares_due.size();
    end
  end

endmodule

>>> sim/bitmap_text_glyph_rasterizer_core_test.sv
// ----------------------------------------------------------------------------
// bitmap_text_glyph_rasterizer_core_test
// Drives text characters into the rasterizer: a directed string set covering
// reset state, coordinate wrap, zero and full scale, blank and unknown codes,
// then random strings under several idle and stall patterns. A checker module
// beside the block predicts and compares every square.
// ----------------------------------------------------------------------------
module bitmap_text_glyph_rasterizer_core_test;
  import btgr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASE_ITEMS  = 90;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  int fail_count;
  int squares_due;
  int tx_idle_pct;
  int rx_stall_pct;
  int quiet_cycles = 0;

  string glyph_chars = "ACDEILM0123456789HNOPRSTUVWXY!./: ";

  bitmap_text_glyph_rasterizer_core #(
    .COORD_BITS(16)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  btgr_square_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .squares_due_o (squares_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // End the run when neither channel moves a transaction for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_glyph(input logic [7:0] code, input logic start,
                            input logic [15:0] ox, input logic [15:0] oy,
                            input logic [3:0] scale, input logic [31:0] color);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tdata  = {4'b0, color, scale, oy, ox, code};
    s_axis_tuser  = start;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_plain(input logic [7:0] code);
    send_glyph(code, 1'b0, 16'($urandom), 16'($urandom), 4'($urandom), $urandom);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (squares_due != 0) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_coord();
    // lean on the wrap points now and then
    if ($urandom_range(4) == 0)
      return 16'h8000 - 16'($urandom_range(48));
    return 16'($urandom);
  endfunction

  task automatic run_strings(input int n_items);
    int          left;
    int          len;
    int          pick;
    logic [7:0]  code;
    logic        start;
    logic [3:0]  scale;
    left = n_items;
    while (left > 0) begin
      len = $urandom_range(8, 1);
      for (int i = 0; i < len && left > 0; i++) begin
        pick = $urandom_range(99);
        if (pick < 65) begin
          code = glyph_chars[$urandom_range(glyph_chars.len() - 1)];
        end else if (pick < 75) begin
          code = " ";
        end else begin
          code = 8'($urandom);
        end
        // mostly well-formed strings; sometimes a missing or stray start
        start = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
        scale = ($urandom_range(7) == 0) ? 4'd0 : 4'($urandom_range(15));
        send_glyph(code, start, pick_coord(), pick_coord(), scale, $urandom);
        left--;
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset pen, extremes of origin and scale, blank and unknown.
    send_plain("A");
    send_glyph("M", 1'b1, 16'h7FFF, 16'h8000, 4'd0, 32'hFFFF_FFFF);
    send_plain("W");
    send_plain(" ");
    send_plain(8'hFF);
    send_glyph("8", 1'b1, 16'h8000, 16'h7FFF, 4'd15, 32'h0000_0000);
    send_plain(8'h80);
    send_plain(8'h00);
    send_plain(8'h7F);
    send_plain(".");
    send_plain("/");
    send_plain(":");
    send_plain("!");
    send_glyph(" ", 1'b1, 16'h7FFF, 16'h7FFF, 4'd15, 32'hA5A5_5A5A);
    send_plain("0");
    send_plain("?");
    send_glyph("E", 1'b1, 16'h0000, 16'h0000, 4'd1, 32'h1234_5678);
    send_glyph("I", 1'b1, 16'hFFFF, 16'hFFFF, 4'd8, 32'h8765_4321);
    send_plain("4");
    wait_drained();

    // Random strings: no idling, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 82; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 82; end
        default: begin tx_idle_pct = 21; rx_stall_pct = 21; end
      endcase
      run_strings(PHASE_ITEMS);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && squares_due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
